// ----- src/stopg_pkg.sv -----
package stopg_pkg;

    // Font geometry
    localparam int GLYPH_W = 5;
    localparam int GLYPH_H = 7;

    // Stream and configuration port widths
    localparam int S_TDATA_W  = 40;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Datapath widths
    localparam int DVD_W   = 18;  // widest dividend: column sum before the wrap
    localparam int DVS_W   = 16;  // widest divisor: the scroll cycle length
    localparam int NBITS_W = 5;   // holds a dividend bit count up to DVD_W
    localparam int OFF_W   = 24;  // scroll offset, Q8, below cycle * 256 when a tick writes it
    localparam int CELL_W  = 9;   // (5 + spacing) * scale
    localparam int CNT_W   = 7;   // text_count register

    // Request kinds carried in s_tuser
    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    // Pixel classes returned in m_tdata
    typedef enum logic [1:0] {
        PIX_CLEAR = 2'd0,
        PIX_BAR   = 2'd1,
        PIX_TEXT  = 2'd2
    } pix_class_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_SCALE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHAR_SPACING  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_GAP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BAR_ROWS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_COLS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_ROWS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_COUNT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_PER_TICK = 3'd7;

    // Character codes used by the normalizer
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_LF      = 8'h0A;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;
    localparam logic [6:0] CHAR_SPACE   = 7'h20;

    // Control of one divider run
    typedef struct packed {
        logic               start;
        logic [NBITS_W-1:0] nbits;
    } div_ctl_t;

    // One glyph: row 0 is the top row, bit 4 of a row is the leftmost column.
    typedef logic [0:GLYPH_H-1][GLYPH_W-1:0] glyph_t;

    // Map a raw byte to the stored 7-bit code.
    function automatic logic [6:0] norm_char(input logic [7:0] c);
        logic [7:0] up;
        up = c - CASE_OFFSET;
        if (c[7] || c == CHAR_CR || c == CHAR_LF || c == CHAR_TAB) begin
            return CHAR_SPACE;
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            return up[6:0];
        end else begin
            return c[6:0];
        end
    endfunction

    // 5x7 font; codes outside the font get the fallback glyph.
    function automatic glyph_t glyph_lookup(input logic [6:0] code);
        case (code)
            7'h41: return {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11}; // A
            7'h42: return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E}; // B
            7'h43: return {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E}; // C
            7'h44: return {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E}; // D
            7'h45: return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F}; // E
            7'h46: return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10}; // F
            7'h47: return {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E}; // G
            7'h48: return {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11}; // H
            7'h49: return {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E}; // I
            7'h4A: return {5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C}; // J
            7'h4B: return {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11}; // K
            7'h4C: return {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F}; // L
            7'h4D: return {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11}; // M
            7'h4E: return {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11}; // N
            7'h4F: return {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E}; // O
            7'h50: return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10}; // P
            7'h51: return {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D}; // Q
            7'h52: return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11}; // R
            7'h53: return {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E}; // S
            7'h54: return {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04}; // T
            7'h55: return {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E}; // U
            7'h56: return {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04}; // V
            7'h57: return {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11}; // W
            7'h58: return {5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h0A, 5'h11}; // X
            7'h59: return {5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04}; // Y
            7'h5A: return {5'h1F, 5'h02, 5'h04, 5'h04, 5'h08, 5'h10, 5'h1F}; // Z
            7'h30: return {5'h0E, 5'h13, 5'h15, 5'h15, 5'h19, 5'h11, 5'h0E}; // 0
            7'h31: return {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E}; // 1
            7'h32: return {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F}; // 2
            7'h33: return {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E}; // 3
            7'h34: return {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02}; // 4
            7'h35: return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E}; // 5
            7'h36: return {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E}; // 6
            7'h37: return {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08}; // 7
            7'h38: return {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E}; // 8
            7'h39: return {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E}; // 9
            7'h2E: return {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h04}; // period
            7'h2C: return {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h08}; // comma
            7'h21: return {5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04}; // exclamation
            7'h3F: return {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04}; // question
            7'h2D: return {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00}; // minus
            7'h3A: return {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00}; // colon
            7'h3B: return {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h08, 5'h00}; // semicolon
            7'h2F: return {5'h01, 5'h02, 5'h04, 5'h04, 5'h08, 5'h10, 5'h00}; // slash
            7'h28: return {5'h02, 5'h04, 5'h08, 5'h08, 5'h08, 5'h04, 5'h02}; // open paren
            7'h29: return {5'h08, 5'h04, 5'h02, 5'h02, 5'h02, 5'h04, 5'h08}; // close paren
            7'h27: return {5'h04, 5'h04, 5'h02, 5'h00, 5'h00, 5'h00, 5'h00}; // apostrophe
            7'h22: return {5'h0A, 5'h0A, 5'h04, 5'h00, 5'h00, 5'h00, 5'h00}; // double quote
            7'h26: return {5'h0C, 5'h12, 5'h14, 5'h08, 5'h15, 5'h12, 5'h0D}; // ampersand
            7'h2B: return {5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00}; // plus
            7'h3D: return {5'h00, 5'h1F, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00}; // equals
            7'h5F: return {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F}; // underscore
            7'h25: return {5'h19, 5'h1A, 5'h02, 5'h04, 5'h08, 5'h16, 5'h13}; // percent
            7'h23: return {5'h0A, 5'h1F, 5'h0A, 5'h0A, 5'h1F, 5'h0A, 5'h0A}; // hash
            7'h40: return {5'h0E, 5'h11, 5'h17, 5'h15, 5'h17, 5'h10, 5'h0E}; // at sign
            default: return {5'h1F, 5'h11, 5'h02, 5'h04, 5'h04, 5'h00, 5'h04};
        endcase
    endfunction

endpackage

// ----- src/stopg_div.sv -----
// Restoring divider: one quotient bit per cycle, nbits quotient bits per run.
// The run consumes the low nbits of the dividend, most significant first.
module stopg_div
    import stopg_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  div_ctl_t         ctl,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient,
    output logic [DVS_W-1:0] remainder
);

    logic               busy_reg;
    logic               done_reg;
    logic [NBITS_W-1:0] cnt_reg;
    logic [DVD_W-1:0]   dvd_reg;
    logic [DVS_W-1:0]   dvs_reg;
    logic [DVD_W-1:0]   quo_reg;
    logic [DVS_W-1:0]   rem_reg;

    logic [DVS_W:0]     rem_sh;
    logic [DVS_W:0]     rem_sub;
    logic               fits;

    // Shift in the next dividend bit and try a subtract.
    always_comb begin
        rem_sh  = {rem_reg, dvd_reg[cnt_reg]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        fits    = rem_sh >= {1'b0, dvs_reg};
    end

    // Run control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            cnt_reg <= ctl.nbits - 1'b1;
            quo_reg <= '0;
            rem_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- src/scrolling_text_overlay_pixel_gen.sv -----
// Scrolling text bar overlay with a built-in 5x7 font.
// Input channel (s_*): one transaction per request. s_tuser selects a character
// write, a scroll tick or a pixel query; s_tdata carries the slot, the byte and
// the screen coordinate. Every request yields exactly one result transaction on
// the m_* channel whose m_tdata holds the pixel class (0 transparent, 1 bar,
// 2 text); writes, ticks and REQ_NONE requests answer 0.
// Configuration is written through cfg_wr_en / cfg_index / cfg_data; the user must
// write it only while no request is in flight, as the block does not enforce this.
// Queries run up to six divisions (row, screen wrap, offset wrap, column wrap,
// character index, glyph column) and ticks at most one, all on one shared
// restoring divider that yields one quotient bit per cycle, so the divider sets
// the item time. One request is in work at a time; s_tready is high only while
// the sequencer is idle.
// The finished result sits in the output register, so the next request is
// taken while the receiver stalls; a second result waits until that register
// is free. Reset clears the scroll offset, loads the default configuration and
// empties the output register. The text store is not cleared.
module scrolling_text_overlay_pixel_gen
    import stopg_pkg::*;
#(
    parameter int TEXT_MAX = 64
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // char_slot[5:0], char_code[13:6], query_x[25:14], query_y[37:26], zero fill
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // req_type[1:0]
    input  logic [S_TUSER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // pixel_class[1:0], zero fill
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CELL,
        S_CYC,
        S_CHK,
        S_TICK_DIV,
        S_ROW_DIV,
        S_WRAP_DIV,
        S_OFF_DIV,
        S_POS_DIV,
        S_IDX_DIV,
        S_COL_DIV,
        S_DONE
    } state_t;

    // Configuration registers
    logic [3:0]       scale_reg;
    logic [3:0]       spacing_reg;
    logic [7:0]       gap_reg;
    logic [9:0]       bar_rows_reg;
    logic [11:0]      cols_reg;
    logic [11:0]      rows_reg;
    logic [CNT_W-1:0] count_reg;
    logic [15:0]      step_reg;

    // Sequencer registers
    state_t           state_reg;
    req_t             req_reg;
    logic [11:0]      x_reg;
    logic [11:0]      y_reg;
    logic [CELL_W-1:0] cell_reg;
    logic [6:0]       s7_reg;
    logic [10:0]      half_reg;
    logic [11:0]      bar_top_reg;
    logic [15:0]      textw_reg;
    logic [DVS_W-1:0] cyc_reg;
    logic [13:0]      rel_reg;
    logic             in_bar_reg;
    logic [2:0]       row_reg;
    logic [DVS_W-1:0] cr_reg;
    logic [7:0]       lo8_reg;
    logic [OFF_W-1:0] off_reg;
    pix_class_t       res_reg;
    logic             m_tvalid_reg;
    pix_class_t       m_class_reg;

    // Divider launch registers
    logic               div_start_reg;
    logic [NBITS_W-1:0] div_nbits_reg;
    logic [DVD_W-1:0]   div_dvd_reg;
    logic [DVS_W-1:0]   div_dvs_reg;

    // Text store
    logic [6:0]       text_mem [TEXT_MAX];
    logic [6:0]       mem_rd_reg;

    // Combinational helpers
    req_t             in_type;
    logic [5:0]       in_slot;
    logic [7:0]       in_code;
    logic [11:0]      in_x;
    logic [11:0]      in_y;
    logic             s_acc;
    logic             mem_we;
    logic             mem_re;
    logic [3:0]       scale_eff;
    logic [CNT_W-1:0] count_eff;
    logic [4:0]       cell_w;
    logic [6:0]       s7;
    logic [10:0]      d;
    logic [10:0]      d_adj;
    logic [13:0]      text_top;
    logic [15:0]      textw;
    logic [OFF_W:0]   tick_sum;
    logic [DVD_W-1:0] pos_sum;
    pix_class_t       bar_class;
    glyph_t           glyph;
    logic [GLYPH_W-1:0] glyph_row;
    logic             pixel_on;
    div_ctl_t         div_ctl;
    logic             div_done;
    logic [DVD_W-1:0] div_quot;
    logic [DVS_W-1:0] div_rem;

    // Field unpacking
    assign in_type  = req_t'(s_tuser);
    assign in_slot  = s_tdata[5:0];
    assign in_code  = s_tdata[13:6];
    assign in_x     = s_tdata[25:14];
    assign in_y     = s_tdata[37:26];
    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    // Effective settings and geometry
    always_comb begin
        scale_eff = (scale_reg == '0) ? 4'd1 : scale_reg;
        count_eff = (32'(count_reg) > TEXT_MAX) ? CNT_W'(TEXT_MAX) : count_reg;
        cell_w    = 5'(GLYPH_W) + {1'b0, spacing_reg};
        s7        = {scale_eff, 3'b000} - {3'b000, scale_eff};
        // Bar rows minus glyph height, halved with truncation toward zero.
        d         = {1'b0, bar_rows_reg} - {4'b0000, s7};
        d_adj     = d + {10'd0, d[10]};
        text_top  = {2'b00, bar_top_reg} + {{3{half_reg[10]}}, half_reg};
        textw     = 16'(count_eff) * 16'(cell_reg);
        tick_sum  = {1'b0, off_reg} + (OFF_W + 1)'(step_reg);
        pos_sum   = DVD_W'(x_reg) + DVD_W'(div_rem) + DVD_W'(cr_reg);
        bar_class = in_bar_reg ? PIX_BAR : PIX_CLEAR;
    end

    // Glyph pixel for the finished column division
    always_comb begin
        glyph     = glyph_lookup(mem_rd_reg);
        glyph_row = glyph[row_reg];
        pixel_on  = (div_quot < DVD_W'(GLYPH_W)) && (mem_rd_reg != CHAR_SPACE) &&
                    glyph_row[3'(GLYPH_W - 1) - div_quot[2:0]];
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg    <= 4'd4;
            spacing_reg  <= 4'd1;
            gap_reg      <= 8'd14;
            bar_rows_reg <= 10'd56;
            cols_reg     <= 12'd1920;
            rows_reg     <= 12'd1080;
            count_reg    <= '0;
            step_reg     <= 16'd384;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PIXEL_SCALE:   scale_reg    <= cfg_data[3:0];
                REG_CHAR_SPACING:  spacing_reg  <= cfg_data[3:0];
                REG_REPEAT_GAP:    gap_reg      <= cfg_data[7:0];
                REG_BAR_ROWS:      bar_rows_reg <= cfg_data[9:0];
                REG_SCREEN_COLS:   cols_reg     <= cfg_data[11:0];
                REG_SCREEN_ROWS:   rows_reg     <= cfg_data[11:0];
                REG_TEXT_COUNT:    count_reg    <= cfg_data[CNT_W-1:0];
                REG_STEP_PER_TICK: step_reg     <= cfg_data[15:0];
            endcase
        end
    end

    // Text store: written on a character write, read by the character index.
    assign mem_we = s_acc && (in_type == REQ_WRITE) && (32'(in_slot) < TEXT_MAX);
    assign mem_re = (state_reg == S_IDX_DIV) && div_done;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            text_mem[IDX_W'(in_slot)] <= norm_char(in_code);
        end
        if (mem_re) begin
            mem_rd_reg <= text_mem[IDX_W'(div_quot)];
        end
    end

    // Shared divider
    assign div_ctl.start = div_start_reg;
    assign div_ctl.nbits = div_nbits_reg;

    stopg_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (div_ctl),
        .dividend  (div_dvd_reg),
        .divisor   (div_dvs_reg),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            m_tvalid_reg  <= 1'b0;
            div_start_reg <= 1'b0;
            off_reg       <= '0;
        end else begin
            div_start_reg <= 1'b0;
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        req_reg <= in_type;
                        x_reg   <= in_x;
                        y_reg   <= in_y;
                        res_reg <= PIX_CLEAR;
                        if (in_type == REQ_TICK || in_type == REQ_QUERY) begin
                            state_reg <= S_CELL;
                        end else begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                // Cell width and vertical placement of the text.
                S_CELL: begin
                    cell_reg    <= CELL_W'(cell_w) * CELL_W'(scale_eff);
                    s7_reg      <= s7;
                    half_reg    <= {d_adj[10], d_adj[10:1]};
                    bar_top_reg <= (rows_reg >= {2'b00, bar_rows_reg}) ?
                                   rows_reg - {2'b00, bar_rows_reg} : '0;
                    state_reg   <= S_CYC;
                end
                // Text width, cycle length and row inside the text band.
                S_CYC: begin
                    textw_reg  <= textw;
                    cyc_reg    <= textw + 16'(gap_reg);
                    rel_reg    <= {2'b00, y_reg} - text_top;
                    in_bar_reg <= y_reg >= bar_top_reg;
                    state_reg  <= S_CHK;
                end
                S_CHK: begin
                    if (req_reg == REQ_TICK) begin
                        if (count_eff == '0) begin
                            state_reg <= S_DONE;
                        end else if (cyc_reg <= 16'd1) begin
                            off_reg   <= '0;
                            state_reg <= S_DONE;
                        end else begin
                            // New offset is (sum >> 8) mod cycle, low byte kept.
                            lo8_reg       <= tick_sum[7:0];
                            div_start_reg <= 1'b1;
                            div_dvd_reg   <= DVD_W'(tick_sum[OFF_W:8]);
                            div_dvs_reg   <= cyc_reg;
                            div_nbits_reg <= NBITS_W'(OFF_W - 7);
                            state_reg     <= S_TICK_DIV;
                        end
                    end else if (count_eff == '0 || x_reg >= cols_reg || y_reg >= rows_reg) begin
                        res_reg   <= PIX_CLEAR;
                        state_reg <= S_DONE;
                    end else if (rel_reg[13] || rel_reg[12:0] >= 13'(s7_reg)) begin
                        res_reg   <= bar_class;
                        state_reg <= S_DONE;
                    end else begin
                        // Glyph row: rel / scale.
                        div_start_reg <= 1'b1;
                        div_dvd_reg   <= DVD_W'(rel_reg[6:0]);
                        div_dvs_reg   <= DVS_W'(scale_eff);
                        div_nbits_reg <= NBITS_W'(7);
                        state_reg     <= S_ROW_DIV;
                    end
                end
                S_TICK_DIV: begin
                    if (div_done) begin
                        off_reg   <= {div_rem, lo8_reg};
                        state_reg <= S_DONE;
                    end
                end
                S_ROW_DIV: begin
                    if (div_done) begin
                        // Screen width modulo the cycle.
                        row_reg       <= div_quot[2:0];
                        div_start_reg <= 1'b1;
                        div_dvd_reg   <= DVD_W'(cols_reg);
                        div_dvs_reg   <= cyc_reg;
                        div_nbits_reg <= NBITS_W'(12);
                        state_reg     <= S_WRAP_DIV;
                    end
                end
                S_WRAP_DIV: begin
                    if (div_done) begin
                        // Whole-pixel offset modulo the cycle.
                        cr_reg        <= cyc_reg - div_rem;
                        div_start_reg <= 1'b1;
                        div_dvd_reg   <= DVD_W'(off_reg[OFF_W-1:8]);
                        div_dvs_reg   <= cyc_reg;
                        div_nbits_reg <= NBITS_W'(OFF_W - 8);
                        state_reg     <= S_OFF_DIV;
                    end
                end
                S_OFF_DIV: begin
                    if (div_done) begin
                        // Position inside the repeating cycle.
                        div_start_reg <= 1'b1;
                        div_dvd_reg   <= pos_sum;
                        div_dvs_reg   <= cyc_reg;
                        div_nbits_reg <= NBITS_W'(DVD_W);
                        state_reg     <= S_POS_DIV;
                    end
                end
                S_POS_DIV: begin
                    if (div_done) begin
                        if (div_rem >= textw_reg) begin
                            res_reg   <= bar_class;
                            state_reg <= S_DONE;
                        end else begin
                            // Character index and pixel inside the cell.
                            div_start_reg <= 1'b1;
                            div_dvd_reg   <= DVD_W'(div_rem);
                            div_dvs_reg   <= DVS_W'(cell_reg);
                            div_nbits_reg <= NBITS_W'(DVS_W);
                            state_reg     <= S_IDX_DIV;
                        end
                    end
                end
                S_IDX_DIV: begin
                    if (div_done) begin
                        // Font column: pixel inside the cell / scale.
                        div_start_reg <= 1'b1;
                        div_dvd_reg   <= DVD_W'(div_rem[CELL_W-1:0]);
                        div_dvs_reg   <= DVS_W'(scale_eff);
                        div_nbits_reg <= NBITS_W'(CELL_W);
                        state_reg     <= S_COL_DIV;
                    end
                end
                S_COL_DIV: begin
                    if (div_done) begin
                        res_reg   <= pixel_on ? PIX_TEXT : bar_class;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_class_reg  <= res_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W - 2)'(0), m_class_reg};

endmodule

// ----- src/stopg_sva.sv -----
// Port-level checks for the scrolling text overlay.
module stopg_sva
    import stopg_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [S_TDATA_W-1:0]  s_tdata,
    input logic [S_TUSER_W-1:0]  s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,
    input logic                  cfg_wr_en,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One request at a time: the input closes after each transaction.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a transaction");

    // A character write into an empty output answers transparent straight from the done state.
    a_write_answer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == REQ_WRITE && !m_tvalid
        |-> ##2 (m_tvalid && m_tdata[1:0] == PIX_CLEAR))
        else $error("character write did not answer transparent");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind scrolling_text_overlay_pixel_gen stopg_sva u_stopg_sva (.*);

// ----- tb/sv/scrolling_text_overlay_pixel_gen_tb.sv -----
`timescale 1ns / 100ps

module scrolling_text_overlay_pixel_gen_tb;
    import stopg_pkg::*;

    localparam int TEXT_SLOTS  = 64;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 120;

    // One full set of configuration registers, at the register widths.
    typedef struct packed {
        logic [3:0]  scale;
        logic [3:0]  spacing;
        logic [7:0]  gap;
        logic [9:0]  bar;
        logic [11:0] cols;
        logic [11:0] rows;
        logic [6:0]  count;
        logic [15:0] step;
    } marquee_cfg_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor state: text store, Q8 scroll offset and register copy.
    logic [6:0]   text_mem [TEXT_SLOTS];
    int           scroll_q8;
    marquee_cfg_t model_cfg;

    // Pixel classes still owed by the block, oldest first.
    pix_class_t   pending_class_q [$];
    pix_class_t   want_class;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count    = 0;
    int n_checked     = 0;
    int n_writes      = 0;
    int n_ticks       = 0;
    int n_queries     = 0;
    int n_text_hits   = 0;
    int n_settings    = 0;
    int unsigned cycle_count = 0;

    scrolling_text_overlay_pixel_gen dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // 5x7 font, row 0 in the top five bits, leftmost column as the MSB of a row.
    function automatic logic [34:0] font_word(input logic [6:0] code);
        case (code)
            "A": return {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            "B": return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
            "C": return {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
            "D": return {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
            "E": return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
            "F": return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
            "G": return {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E};
            "H": return {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            "I": return {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            "J": return {5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C};
            "K": return {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
            "L": return {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
            "M": return {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
            "N": return {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
            "O": return {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            "P": return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
            "Q": return {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
            "R": return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
            "S": return {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
            "T": return {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            "U": return {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            "V": return {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
            "W": return {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11};
            "X": return {5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h0A, 5'h11};
            "Y": return {5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            "Z": return {5'h1F, 5'h02, 5'h04, 5'h04, 5'h08, 5'h10, 5'h1F};
            "0": return {5'h0E, 5'h13, 5'h15, 5'h15, 5'h19, 5'h11, 5'h0E};
            "1": return {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            "2": return {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
            "3": return {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
            "4": return {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
            "5": return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
            "6": return {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
            "7": return {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
            "8": return {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
            "9": return {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E};
            ".": return {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h04};
            ",": return {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h08};
            "!": return {5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04};
            "?": return {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04};
            "-": return {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
            ":": return {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
            ";": return {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h08, 5'h00};
            "/": return {5'h01, 5'h02, 5'h04, 5'h04, 5'h08, 5'h10, 5'h00};
            "(": return {5'h02, 5'h04, 5'h08, 5'h08, 5'h08, 5'h04, 5'h02};
            ")": return {5'h08, 5'h04, 5'h02, 5'h02, 5'h02, 5'h04, 5'h08};
            "'": return {5'h04, 5'h04, 5'h02, 5'h00, 5'h00, 5'h00, 5'h00};
            "\"": return {5'h0A, 5'h0A, 5'h04, 5'h00, 5'h00, 5'h00, 5'h00};
            "&": return {5'h0C, 5'h12, 5'h14, 5'h08, 5'h15, 5'h12, 5'h0D};
            "+": return {5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00};
            "=": return {5'h00, 5'h1F, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
            "_": return {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F};
            "%": return {5'h19, 5'h1A, 5'h02, 5'h04, 5'h08, 5'h16, 5'h13};
            "#": return {5'h0A, 5'h1F, 5'h0A, 5'h0A, 5'h1F, 5'h0A, 5'h0A};
            "@": return {5'h0E, 5'h11, 5'h17, 5'h15, 5'h17, 5'h10, 5'h0E};
            default: return {5'h1F, 5'h11, 5'h02, 5'h04, 5'h04, 5'h00, 5'h04};
        endcase
    endfunction

    // Stored form of a raw byte: high codes and whitespace to space, upper case.
    function automatic logic [6:0] stored_char(input logic [7:0] c);
        if (c[7] || c == CHAR_CR || c == CHAR_LF || c == CHAR_TAB) begin
            return CHAR_SPACE;
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            return 7'(c - CASE_OFFSET);
        end
        return c[6:0];
    endfunction

    function automatic int glyph_scale();
        return (model_cfg.scale == 0) ? 1 : int'(model_cfg.scale);
    endfunction

    function automatic int text_chars();
        return (model_cfg.count > TEXT_SLOTS) ? TEXT_SLOTS : int'(model_cfg.count);
    endfunction

    function automatic int scroll_cycle();
        return text_chars() * (GLYPH_W + int'(model_cfg.spacing)) * glyph_scale()
            + int'(model_cfg.gap);
    endfunction

    function automatic int bar_top_row();
        int btop;
        btop = int'(model_cfg.rows) - int'(model_cfg.bar);
        return (btop < 0) ? 0 : btop;
    endfunction

    // Glyphs sit centered in the bar; the division truncates toward zero.
    function automatic int text_top_row();
        return bar_top_row() + (int'(model_cfg.bar) - GLYPH_H * glyph_scale()) / 2;
    endfunction

    // Class of one screen pixel under the current text, offset and registers.
    function automatic pix_class_t classify_pixel(input int x, input int y);
        int          n, s, cell_px, cyc, off_px, pos, idx, col, row, rel;
        logic [6:0]  code;
        logic [34:0] bits;
        pix_class_t  background;
        n = text_chars();
        s = glyph_scale();
        if (n == 0 || x >= int'(model_cfg.cols) || y >= int'(model_cfg.rows)) begin
            return PIX_CLEAR;
        end
        background = (y >= bar_top_row()) ? PIX_BAR : PIX_CLEAR;
        rel = y - text_top_row();
        if (rel < 0 || rel >= GLYPH_H * s) begin
            return background;
        end
        row = rel / s;
        cell_px = (GLYPH_W + int'(model_cfg.spacing)) * s;
        cyc = n * cell_px + int'(model_cfg.gap);
        // A stale offset from an older, longer cycle is folded into this one.
        off_px = (scroll_q8 % (cyc * 256)) / 256;
        pos = (x + off_px + cyc - (int'(model_cfg.cols) % cyc)) % cyc;
        if (pos >= n * cell_px) begin
            return background;
        end
        idx = pos / cell_px;
        col = (pos % cell_px) / s;
        code = text_mem[idx];
        bits = font_word(code);
        if (col < GLYPH_W && code != CHAR_SPACE && bits[34 - GLYPH_W * row - col]) begin
            return PIX_TEXT;
        end
        return background;
    endfunction

    // Applies one accepted request to the predictor and returns its pixel class.
    function automatic pix_class_t marquee_response(input req_t req, input logic [5:0] slot,
                                                    input logic [7:0] code,
                                                    input logic [11:0] x, input logic [11:0] y);
        pix_class_t result;
        int         cyc;
        result = PIX_CLEAR;
        case (req)
            REQ_WRITE: begin
                text_mem[slot] = stored_char(code);
                n_writes++;
            end
            REQ_TICK: begin
                n_ticks++;
                if (text_chars() != 0) begin
                    cyc = scroll_cycle();
                    if (cyc <= 1) begin
                        scroll_q8 = 0;
                    end else begin
                        scroll_q8 = ((scroll_q8 & 32'h0FFF_FFFF) + int'(model_cfg.step))
                            % (cyc * 256);
                    end
                end
            end
            REQ_QUERY: begin
                result = classify_pixel(int'(x), int'(y));
                n_queries++;
                if (result == PIX_TEXT) begin
                    n_text_hits++;
                end
            end
            default: begin
            end
        endcase
        return result;
    endfunction

    function automatic marquee_cfg_t make_cfg(input int scale, input int spacing, input int gap,
                                              input int bar, input int cols, input int rows,
                                              input int count, input int step);
        marquee_cfg_t c;
        c.scale   = 4'(scale);
        c.spacing = 4'(spacing);
        c.gap     = 8'(gap);
        c.bar     = 10'(bar);
        c.cols    = 12'(cols);
        c.rows    = 12'(rows);
        c.count   = 7'(count);
        c.step    = 16'(step);
        return c;
    endfunction

    // Mostly printable font characters, with lower case and arbitrary bytes mixed in.
    function automatic logic [7:0] random_char();
        case ($urandom_range(3))
            0:       return 8'($urandom_range(255));
            1:       return 8'($urandom_range(CHAR_LOWER_Z, CHAR_LOWER_A));
            default: return 8'($urandom_range(8'h5F, 8'h20));
        endcase
    endfunction

    // Sends one request and records its expected class once it is accepted.
    task automatic send_item(input req_t req, input logic [5:0] slot, input logic [7:0] code,
                             input logic [11:0] x, input logic [11:0] y);
        @(posedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= S_TDATA_W'({y, x, code, slot});
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        s_tvalid <= 1'b0;
        pending_class_q.push_back(marquee_response(req, slot, code, x, y));
    endtask

    task automatic wait_idle();
        while (pending_class_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Writes all eight registers once the block has delivered every result.
    task automatic apply_config(input marquee_cfg_t c);
        logic [CFG_IDX_W-1:0] ri;
        wait_idle();
        @(posedge aclk);
        for (int i = 0; i < 8; i++) begin
            ri = i[CFG_IDX_W-1:0];
            cfg_wr_en <= 1'b1;
            cfg_index <= ri;
            case (ri)
                REG_PIXEL_SCALE:   cfg_data <= CFG_DATA_W'(c.scale);
                REG_CHAR_SPACING:  cfg_data <= CFG_DATA_W'(c.spacing);
                REG_REPEAT_GAP:    cfg_data <= CFG_DATA_W'(c.gap);
                REG_BAR_ROWS:      cfg_data <= CFG_DATA_W'(c.bar);
                REG_SCREEN_COLS:   cfg_data <= CFG_DATA_W'(c.cols);
                REG_SCREEN_ROWS:   cfg_data <= CFG_DATA_W'(c.rows);
                REG_TEXT_COUNT:    cfg_data <= CFG_DATA_W'(c.count);
                REG_STEP_PER_TICK: cfg_data <= c.step;
                default:           cfg_data <= '0;
            endcase
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        model_cfg = c;
        n_settings++;
    endtask

    // Right after reset the text count is zero: nothing is drawn, ticks do nothing.
    task automatic test_empty_text();
        send_item(REQ_QUERY, 6'd0, 8'h00, 12'd100, 12'd1060);
        send_item(REQ_TICK, 6'd0, 8'h00, 12'd0, 12'd0);
        send_item(REQ_NONE, 6'h3F, 8'hFF, 12'hFFF, 12'hFFF);
    endtask

    // Fills every slot so that no query ever reads an unwritten entry.
    task automatic test_text_load();
        logic [7:0] specials [12];
        specials = '{8'hFF, 8'h80, CHAR_CR, CHAR_LF, CHAR_TAB, CHAR_LOWER_A, CHAR_LOWER_Z,
                     8'h60, 8'h7B, 8'h00, 8'h7F, 8'h20};
        for (int i = 0; i < TEXT_SLOTS; i++) begin
            send_item(REQ_WRITE, 6'(i), (i < 12) ? specials[i] : random_char(),
                      12'($urandom_range(4095)), 12'($urandom_range(4095)));
        end
    endtask

    task automatic test_corner_cases();
        // Small screen, one-pixel glyphs, cycle equal to the text width.
        apply_config(make_cfg(1, 0, 0, 24, 40, 30, 8, 256));
        send_item(REQ_QUERY, 6'd0, 8'h00, 12'd0, 12'd14);
        send_item(REQ_QUERY, 6'd0, 8'h00, 12'd2, 12'd17);
        send_item(REQ_QUERY, 6'd0, 8'h00, 12'd39, 12'd20);
        send_item(REQ_QUERY, 6'd0, 8'h00, 12'd5, 12'd5);
        send_item(REQ_QUERY, 6'd0, 8'h00, 12'd5, 12'd6);
        send_item(REQ_QUERY, 6'd0, 8'h00, 12'd40, 12'd15);
        send_item(REQ_QUERY, 6'd0, 8'h00, 12'd0, 12'd30);
        send_item(REQ_TICK, 6'd0, 8'h00, 12'd0, 12'd0);
        send_item(REQ_TICK, 6'd0, 8'h00, 12'd0, 12'd0);
        send_item(REQ_QUERY, 6'd0, 8'h00, 12'd1, 12'd16);

        // Scale zero acts as one, an oversized count is clipped, no bar at all.
        apply_config(make_cfg(0, 2, 3, 0, 40, 30, 100, 256));
        send_item(REQ_QUERY, 6'd0, 8'h00, 12'd3, 12'd27);
        send_item(REQ_QUERY, 6'd0, 8'h00, 12'd3, 12'd29);

        // Bar taller than the screen starts at row zero; text lands off screen.
        apply_config(make_cfg(1, 0, 0, 1023, 40, 30, 8, 256));
        send_item(REQ_QUERY, 6'd0, 8'h00, 12'd3, 12'd20);

        // Every register at its largest value, the text count at the slot count.
        apply_config(make_cfg(15, 15, 255, 1023, 4095, 4095, 64, 65535));
        send_item(REQ_TICK, 6'd0, 8'h00, 12'd0, 12'd0);
        send_item(REQ_TICK, 6'd0, 8'h00, 12'd0, 12'd0);
        send_item(REQ_TICK, 6'd0, 8'h00, 12'd0, 12'd0);
        send_item(REQ_QUERY, 6'd0, 8'h00, 12'd0, 12'd3531);
        send_item(REQ_QUERY, 6'd0, 8'h00, 12'd100, 12'd3600);
        send_item(REQ_QUERY, 6'd0, 8'h00, 12'd4094, 12'd4094);
        send_item(REQ_QUERY, 6'd0, 8'h00, 12'd4095, 12'd4095);

        // Shrinking the cycle after ticks leaves an offset beyond the new cycle.
        apply_config(make_cfg(1, 0, 0, 24, 40, 30, 1, 0));
        send_item(REQ_QUERY, 6'd0, 8'h00, 12'd2, 12'd16);
        send_item(REQ_TICK, 6'd0, 8'h00, 12'd0, 12'd0);
        send_item(REQ_QUERY, 6'd0, 8'h00, 12'd2, 12'd16);

        // Zero-sized screen in either direction draws nothing.
        apply_config(make_cfg(1, 0, 0, 24, 0, 30, 8, 256));
        send_item(REQ_QUERY, 6'd0, 8'h00, 12'd0, 12'd16);
        apply_config(make_cfg(1, 0, 0, 24, 40, 0, 8, 256));
        send_item(REQ_QUERY, 6'd0, 8'h00, 12'd0, 12'd0);
    endtask

    function automatic marquee_cfg_t random_config();
        int kind;
        kind = $urandom_range(99);
        if (kind < 15) begin
            return make_cfg($urandom_range(15), $urandom_range(15), $urandom_range(255),
                            $urandom_range(1023), $urandom_range(4095), $urandom_range(4095),
                            $urandom_range(127), $urandom_range(65535));
        end else if (kind < 22) begin
            if ($urandom_range(1) == 0) begin
                return make_cfg(15, 15, 255, 1023, 4095, 4095, 64, 65535);
            end
            return make_cfg(1, 0, 0, 24, 1, 1, 1, 1);
        end
        // Typical marquee: modest scale, screen a little larger than the bar.
        return make_cfg(($urandom_range(9) == 0) ? $urandom_range(15, 5) : $urandom_range(4, 1),
                        $urandom_range(3), $urandom_range(40), $urandom_range(200, 24),
                        $urandom_range(640, 16), $urandom_range(720, 24),
                        $urandom_range(64, 1), $urandom_range(2048, 1));
    endfunction

    // Random settings, each followed by a burst of writes, ticks, empty requests and mostly aimed queries.
    task automatic test_random_traffic(input int items, input int send_pct, input int recv_pct);
        int sent, burst, pick, aim, qx, qy;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < items) begin
            apply_config(random_config());
            burst = $urandom_range(90, 30);
            for (int k = 0; k < burst && sent < items; k++) begin
                pick = $urandom_range(99);
                qx = $urandom_range(4095);
                qy = $urandom_range(4095);
                if (pick < 15) begin
                    send_item(REQ_WRITE, 6'($urandom_range(63)), random_char(), 12'(qx), 12'(qy));
                end else if (pick < 33) begin
                    send_item(REQ_TICK, 6'($urandom_range(63)), 8'($urandom_range(255)),
                              12'(qx), 12'(qy));
                end else if (pick < 36) begin
                    send_item(REQ_NONE, 6'($urandom_range(63)), 8'($urandom_range(255)),
                              12'(qx), 12'(qy));
                end else begin
                    aim = $urandom_range(99);
                    if (aim < 85) begin
                        qx = (model_cfg.cols == 0) ? 0 : $urandom_range(int'(model_cfg.cols) - 1);
                        if (aim < 65) begin
                            qy = text_top_row() + $urandom_range(GLYPH_H * glyph_scale() - 1);
                        end else begin
                            qy = bar_top_row() + $urandom_range(int'(model_cfg.bar));
                        end
                        qy = (qy < 0) ? 0 : ((qy > 4095) ? 4095 : qy);
                    end
                    send_item(REQ_QUERY, 6'($urandom_range(63)), 8'($urandom_range(255)),
                              12'(qx), 12'(qy));
                end
                sent++;
            end
        end
    endtask

    // Receiver back-pressure.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Each result transaction is checked against the oldest expected class.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_class_q.size() == 0) begin
                $error("pixel_class: no result expected, actual %0d", m_tdata[1:0]);
                fail_count++;
            end else begin
                want_class = pending_class_q.pop_front();
                n_checked++;
                if (m_tdata[1:0] !== want_class) begin
                    $error("pixel_class mismatch: expected %0d, actual %0d",
                           want_class, m_tdata[1:0]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL scrolling_text_overlay_pixel_gen");
            $finish;
        end
    end

    initial begin
        model_cfg = make_cfg(4, 1, 14, 56, 1920, 1080, 0, 384);
        scroll_q8 = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 19;
        recv_idle_pct = 71;
        test_empty_text();
        test_text_load();
        test_corner_cases();
        test_random_traffic(500, 19, 71);
        test_random_traffic(475, 71, 19);
        test_random_traffic(475, 0, 0);

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d character writes, %0d ticks and %0d pixel queries (%0d on glyphs)",
                 n_writes, n_ticks, n_queries, n_text_hits);
        $display("across %0d register settings; %0d results checked, %0d errors.",
                 n_settings, n_checked, fail_count);
        if (fail_count == 0) begin
            $display("PASS scrolling_text_overlay_pixel_gen");
        end else begin
            $display("FAIL scrolling_text_overlay_pixel_gen");
        end
        $finish;
    end

endmodule
